### hdl/fpfa_pkg.sv
// Shared types and codes for the fixed partition fit allocator.
`default_nettype none

package fpfa_pkg;

	localparam int OP_W      = 2;
	localparam int VAL_W     = 16;
	localparam int OUT_IDX_W = 4;
	localparam int MODE_W    = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

	// Fit policy codes
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [VAL_W-1:0] size_value;
	} fpfa_req_t;

	typedef struct packed {
		logic                 granted;
		logic [OUT_IDX_W-1:0] partition_index;
		logic [VAL_W-1:0]     partition_size;
	} fpfa_rsp_t;

endpackage

`default_nettype wire

### hdl/fixed_partition_fit_allocator.sv
// Fixed partition allocator top level: mode register, controller and result register.
//
// Requests arrive on req_valid/req_ready with a fpfa_req_t payload: clear the
// table, load one partition size at the next free position, or allocate.
// Only an allocate produces a transaction on rsp_valid/rsp_ready (fpfa_rsp_t).
// An allocate walks the loaded entries of the size memory one per cycle, and
// the memory read port sets that pace; with an empty table or an unknown fit
// mode it skips the scan and goes straight to the result. req_ready is low
// while an allocate is in flight. A finished result sits in the output
// register while the next request is taken; if the receiver still holds the
// previous result, the controller keeps the new one until the register frees.
// The fit mode is written through cfg_we/cfg_wdata; the user must write it
// only while idle, as the block itself does not enforce this.
// Reset (arst_n low) empties the table, marks all partitions used, sets first
// fit and drops rsp_valid. Size memory contents are undefined until loaded.
`default_nettype none

module fixed_partition_fit_allocator
	import fpfa_pkg::*;
#(
	parameter int MAX_PARTITIONS = 16,
	parameter int SIZE_BITS      = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output      logic              req_ready,
	input  wire fpfa_req_t         req,
	output      logic              rsp_valid,
	input  wire logic              rsp_ready,
	output      fpfa_rsp_t         rsp,
	input  wire logic              cfg_we,
	input  wire logic [MODE_W-1:0] cfg_wdata
);

	logic [MODE_W-1:0] fit_mode_q;
	logic              rsp_valid_q;
	fpfa_rsp_t         rsp_q;
	logic              res_valid;
	logic              res_ready;
	fpfa_rsp_t         res;

	// Hold the fit mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= MODE_FIRST;
		end else if (cfg_we) begin
			fit_mode_q <= cfg_wdata;
		end
	end

	fpfa_ctrl #(
		.MAX_PARTITIONS(MAX_PARTITIONS),
		.SIZE_BITS     (SIZE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.fit_mode (fit_mode_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Load the result register when it is empty or being drained
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The controller never takes a request while a result is pending
	a_no_req_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && res_valid))
		else $error("request accepted while a result is pending");

	// A refused allocation carries zero index and size
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.granted) |->
		((rsp.partition_index == '0) && (rsp.partition_size == '0)))
		else $error("refused allocation with nonzero fields");

	// An accepted allocate blocks new requests in the next cycle
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req.operation == OP_ALLOC)) |=> !req_ready)
		else $error("request taken right after an allocate");

endmodule

`default_nettype wire

### hdl/fpfa_size_ram.sv
// Partition size memory: one write port, one registered read port.
`default_nettype none

module fpfa_size_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, updated when the read is enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/fpfa_ctrl.sv
// Allocation controller: table load and clear, free flags, and the fit scan.
`default_nettype none

module fpfa_ctrl
	import fpfa_pkg::*;
#(
	parameter int MAX_PARTITIONS = 16,
	parameter int SIZE_BITS      = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output      logic              req_ready,
	input  wire fpfa_req_t         req,
	input  wire logic [MODE_W-1:0] fit_mode,
	output      logic              res_valid,
	input  wire logic              res_ready,
	output      fpfa_rsp_t         res
);

	localparam int IDX_W = $clog2(MAX_PARTITIONS);
	localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]                state_q;
	logic [CNT_W-1:0]          count_q;
	logic [MAX_PARTITIONS-1:0] free_q;
	logic [CNT_W-1:0]          issue_cnt_q;
	logic [MODE_W-1:0]         mode_q;
	logic [SIZE_BITS-1:0]      req_size_q;
	logic                      found_q;
	logic [IDX_W-1:0]          pick_q;
	logic [SIZE_BITS-1:0]      pick_size_q;
	logic                      valid_s1;
	logic                      last_s1;
	logic [IDX_W-1:0]          idx_s1;

	logic                       accept;
	logic                       issuing;
	logic                       load_ok;
	logic                       mode_known;
	logic                       hit;
	logic                       better;
	logic [SIZE_BITS-1:0]       rd_data;
	logic [SIZE_BITS+VAL_W-1:0] in_ext;
	logic [SIZE_BITS-1:0]       in_size;
	logic [IDX_W+OUT_IDX_W-1:0] pick_ext;
	logic [SIZE_BITS+VAL_W-1:0] size_ext;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign issuing   = (state_q == ST_SCAN) && (issue_cnt_q < count_q);
	assign load_ok   = (count_q < CNT_W'(MAX_PARTITIONS));
	assign mode_known = (fit_mode == MODE_FIRST) || (fit_mode == MODE_BEST)
		|| (fit_mode == MODE_WORST);

	// Fold the request size into the stored width
	assign in_ext  = {{SIZE_BITS{1'b0}}, req.size_value};
	assign in_size = in_ext[SIZE_BITS-1:0];

	fpfa_size_ram #(
		.DEPTH(MAX_PARTITIONS),
		.WIDTH(SIZE_BITS)
	) u_size_ram (
		.clk    (clk),
		.wr_en  (accept && (req.operation == OP_LOAD) && load_ok),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data(in_size),
		.rd_en  (issuing),
		.rd_addr(issue_cnt_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	// Compare the entry coming back from memory
	assign hit = valid_s1 && free_q[idx_s1] && (rd_data >= req_size_q);
	always_comb begin
		better = 1'b0;
		case (mode_q)
			MODE_BEST:  better = rd_data < pick_size_q;
			MODE_WORST: better = rd_data > pick_size_q;
			default:    better = 1'b0;
		endcase
	end

	// Shape the result
	assign pick_ext = {{OUT_IDX_W{1'b0}}, pick_q};
	assign size_ext = {{VAL_W{1'b0}}, pick_size_q};
	assign res_valid = (state_q == ST_FINISH);
	always_comb begin
		res = '0;
		if (found_q) begin
			res.granted         = 1'b1;
			res.partition_index = pick_ext[OUT_IDX_W-1:0];
			res.partition_size  = size_ext[VAL_W-1:0];
		end
	end

	// Sequence operations, track the table and run the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			free_q      <= '0;
			issue_cnt_q <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			valid_s1 <= issuing;
			if (issuing) begin
				issue_cnt_q <= issue_cnt_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.operation)
							OP_CLEAR: begin
								count_q <= '0;
								free_q  <= '0;
							end
							OP_LOAD: begin
								if (load_ok) begin
									free_q[count_q[IDX_W-1:0]] <= 1'b1;
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_ALLOC: begin
								found_q     <= 1'b0;
								issue_cnt_q <= '0;
								if (!mode_known || (count_q == '0)) begin
									state_q <= ST_FINISH;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit && (!found_q || better)) begin
						found_q <= 1'b1;
					end
					if (valid_s1 && last_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (res_ready) begin
						if (found_q) begin
							free_q[pick_q] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold request payload, tag read data, and keep the current pick
	always_ff @(posedge clk) begin
		idx_s1  <= issue_cnt_q[IDX_W-1:0];
		last_s1 <= (issue_cnt_q == count_q - CNT_W'(1));
		if (accept) begin
			mode_q     <= fit_mode;
			req_size_q <= in_size;
		end
		if ((state_q == ST_SCAN) && hit && (!found_q || better)) begin
			pick_q      <= idx_s1;
			pick_size_q <= rd_data;
		end
	end

endmodule

`default_nettype wire

### bench/tb_fixed_partition_fit_allocator.sv
// Self-checking bench for the fixed partition fit allocator under all fit policies.

module tb_fixed_partition_fit_allocator;
	import fpfa_pkg::*;

	localparam int MAX_PARTS   = 16;
	localparam int TOTAL_ITEMS = 530;
	localparam int TAIL_CYCLES = MAX_PARTS + 8;
	localparam int LONG_HOLD   = 300;

	// Codes the package leaves unnamed
	localparam logic [OP_W-1:0]   OP_NOP    = 2'd3;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	fpfa_req_t         req       = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	fpfa_rsp_t         rsp;
	logic              cfg_we    = 1'b0;
	logic [MODE_W-1:0] cfg_wdata = '0;

	// Shadow of the allocator state
	logic [VAL_W-1:0]  part_size [MAX_PARTS];
	bit                part_free [MAX_PARTS];
	int                loaded_n    = 0;
	logic [MODE_W-1:0] fit_policy  = MODE_FIRST;

	fpfa_req_t pending_reqs [$];
	fpfa_rsp_t expected_grants [$];

	int items_queued    = 0;
	int requests_taken  = 0;
	int results_checked = 0;
	int grants_seen     = 0;
	int fail_count      = 0;
	int gap_left        = 0;
	int hold_left       = 0;
	int holds_asked     = 0;
	int holds_served    = 0;
	bit send_steady     = 1'b0;
	bit recv_steady     = 1'b0;

	fixed_partition_fit_allocator #(
		.MAX_PARTITIONS(MAX_PARTS),
		.SIZE_BITS(VAL_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Mostly no pause, some short ones, a few long ones
	function automatic int draw_pause();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Favor small sizes so ties and exact fits are common
	function automatic logic [VAL_W-1:0] draw_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 25)
			return VAL_W'($urandom_range(0, 15));
		if (roll < 50)
			return VAL_W'($urandom_range(0, 255));
		if (roll < 90)
			return VAL_W'($urandom_range(0, 16'hFFFF));
		return roll[0] ? 16'hFFFF : 16'h0000;
	endfunction

	// Apply one request to the shadow table and queue any allocation result
	function automatic void predict_allocation(input fpfa_req_t r);
		fpfa_rsp_t grant;
		bit        found;
		int        pick;
		grant = '0;
		found = 1'b0;
		pick  = 0;
		case (r.operation)
			OP_CLEAR: begin
				loaded_n = 0;
				for (int k = 0; k < MAX_PARTS; k++)
					part_free[k] = 1'b0;
			end
			OP_LOAD: begin
				if (loaded_n < MAX_PARTS) begin
					part_size[loaded_n] = r.size_value;
					part_free[loaded_n] = 1'b1;
					loaded_n++;
				end
			end
			OP_ALLOC: begin
				if (fit_policy != MODE_NONE) begin
					for (int k = 0; k < loaded_n; k++) begin
						if (part_free[k] && part_size[k] >= r.size_value) begin
							if (!found) begin
								found = 1'b1;
								pick  = k;
								if (fit_policy == MODE_FIRST)
									break;
							end else if (fit_policy == MODE_BEST &&
									part_size[k] < part_size[pick]) begin
								pick = k;
							end else if (fit_policy == MODE_WORST &&
									part_size[k] > part_size[pick]) begin
								pick = k;
							end
						end
					end
				end
				if (found) begin
					part_free[pick]       = 1'b0;
					grant.granted         = 1'b1;
					grant.partition_index = pick[OUT_IDX_W-1:0];
					grant.partition_size  = part_size[pick];
				end
				expected_grants.push_back(grant);
			end
			default: ;
		endcase
	endfunction

	// Drive request transactions from the pending queue with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			gap_left  <= 0;
		end else if (!req_valid || req_ready) begin
			if (gap_left > 0) begin
				req_valid <= 1'b0;
				gap_left  <= gap_left - 1;
			end else if (pending_reqs.size() > 0) begin
				req_valid <= 1'b1;
				req       <= pending_reqs.pop_front();
				gap_left  <= send_steady ? 0 : draw_pause();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random; serve long hold-offs when asked
	always @(posedge clk or negedge arst_n) begin : result_sink
		int pause;
		if (!arst_n) begin
			rsp_ready    <= 1'b0;
			hold_left    <= 0;
			holds_served <= 0;
		end else if (holds_served < holds_asked) begin
			rsp_ready    <= 1'b0;
			hold_left    <= LONG_HOLD - 1;
			holds_served <= holds_served + 1;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			pause = recv_steady ? 0 : draw_pause();
			rsp_ready <= (pause == 0);
			hold_left <= (pause == 0) ? 0 : pause - 1;
		end
	end

	// Check result transactions, then predict from accepted requests
	always @(posedge clk) begin : result_check
		fpfa_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_checked++;
			if (expected_grants.size() == 0) begin
				$error("result with none expected: granted=%0d index=%0d size=%0d",
					rsp.granted, rsp.partition_index, rsp.partition_size);
				fail_count++;
			end else begin
				want = expected_grants.pop_front();
				if (want.granted)
					grants_seen++;
				if (rsp.granted !== want.granted) begin
					$error("granted: expected %0d, actual %0d", want.granted, rsp.granted);
					fail_count++;
				end
				if (rsp.partition_index !== want.partition_index) begin
					$error("partition_index: expected %0d, actual %0d",
						want.partition_index, rsp.partition_index);
					fail_count++;
				end
				if (rsp.partition_size !== want.partition_size) begin
					$error("partition_size: expected %0d, actual %0d",
						want.partition_size, rsp.partition_size);
					fail_count++;
				end
			end
		end
		if (arst_n && req_valid && req_ready) begin
			requests_taken++;
			predict_allocation(req);
		end
	end

	task automatic queue_req(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
		fpfa_req_t r;
		r.operation  = op;
		r.size_value = value;
		pending_reqs.push_back(r);
		items_queued++;
	endtask

	// Block until every request is taken and every result has arrived
	task automatic wait_results();
		@(negedge clk);
		while (pending_reqs.size() > 0 || req_valid || expected_grants.size() > 0)
			@(negedge clk);
	endtask

	// Also let a trailing load or clear finish inside the block
	task automatic wait_idle();
		wait_results();
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic set_fit_policy(input logic [MODE_W-1:0] mode);
		wait_idle();
		@(posedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= mode;
		fit_policy = mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Usually clear, then load a table and allocate against it, with a little noise
	task automatic queue_fit_round();
		int loads;
		int allocs;
		if ($urandom_range(0, 99) < 85)
			queue_req(OP_CLEAR, VAL_W'($urandom_range(0, 16'hFFFF)));
		loads = ($urandom_range(0, 99) < 12) ? $urandom_range(MAX_PARTS, MAX_PARTS + 2)
			: $urandom_range(1, 12);
		repeat (loads) begin
			queue_req(OP_LOAD, draw_size());
			if ($urandom_range(0, 99) < 3)
				queue_req(OP_NOP, VAL_W'($urandom_range(0, 16'hFFFF)));
		end
		allocs = $urandom_range(1, loads + 3);
		repeat (allocs) begin
			queue_req(OP_ALLOC, draw_size());
			if ($urandom_range(0, 99) < 4)
				queue_req(OP_NOP, VAL_W'($urandom_range(0, 16'hFFFF)));
			else if ($urandom_range(0, 99) < 3)
				queue_req(OP_LOAD, draw_size());
		end
	endtask

	// Hold reset, then release it away from the clock edge
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Stimulus sequence: directed cases, then random phases across policies
	initial begin : sequencer
		int phase;
		int rounds;
		logic [MODE_W-1:0] mode;
		wait (arst_n);
		@(negedge clk);

		// First fit from reset: empty table, ignored code, extremes, zero size
		queue_req(OP_ALLOC, 16'd0);
		queue_req(OP_NOP, 16'hFFFF);
		queue_req(OP_LOAD, 16'd0);
		queue_req(OP_LOAD, 16'hFFFF);
		queue_req(OP_LOAD, 16'd100);
		queue_req(OP_LOAD, 16'd100);
		queue_req(OP_ALLOC, 16'd0);
		queue_req(OP_ALLOC, 16'd0);
		queue_req(OP_ALLOC, 16'hFFFF);
		queue_req(OP_ALLOC, 16'd100);
		queue_req(OP_CLEAR, 16'd0);
		queue_req(OP_ALLOC, 16'd0);

		// Best fit with a tie on the smallest size
		set_fit_policy(MODE_BEST);
		queue_req(OP_CLEAR, 16'd0);
		queue_req(OP_LOAD, 16'd30);
		queue_req(OP_LOAD, 16'd10);
		queue_req(OP_LOAD, 16'd20);
		queue_req(OP_LOAD, 16'd10);
		queue_req(OP_ALLOC, 16'd10);
		queue_req(OP_ALLOC, 16'd5);
		queue_req(OP_ALLOC, 16'd25);

		// Worst fit with a tie on the largest size
		set_fit_policy(MODE_WORST);
		queue_req(OP_CLEAR, 16'd0);
		queue_req(OP_LOAD, 16'd5);
		queue_req(OP_LOAD, 16'd9);
		queue_req(OP_LOAD, 16'd9);
		queue_req(OP_ALLOC, 16'd1);
		queue_req(OP_ALLOC, 16'd1);

		// Unknown policy refuses even with a free partition left
		set_fit_policy(MODE_NONE);
		queue_req(OP_ALLOC, 16'd0);

		phase = 0;
		while (items_queued < TOTAL_ITEMS) begin
			case (phase % 5)
				0:       mode = MODE_FIRST;
				1:       mode = MODE_BEST;
				2:       mode = MODE_WORST;
				3:       mode = MODE_NONE;
				default: mode = MODE_W'($urandom_range(MODE_FIRST, MODE_WORST));
			endcase
			set_fit_policy(mode);
			send_steady = (phase % 6 == 2);
			recv_steady = (phase % 6 == 2);

			// Back up the result side while requests keep coming
			if (phase == 1) begin
				holds_asked = holds_asked + 1;
				repeat (6) queue_req(OP_LOAD, draw_size());
				repeat (10) queue_req(OP_ALLOC, draw_size());
			end

			rounds = $urandom_range(2, 5);
			repeat (rounds) begin
				queue_fit_round();
				if ($urandom_range(0, 99) < 25)
					wait_results();
			end
			phase++;
		end
		wait_idle();

		$display("Ran %0d requests over %0d phases under first, best, worst and unknown fit.",
			requests_taken, phase);
		$display("Checked %0d allocation results, %0d of them granted.",
			results_checked, grants_seen);
		if (fail_count == 0 && expected_grants.size() == 0) begin
			$display("** fixed_partition_fit_allocator: PASSED **");
		end else begin
			if (expected_grants.size() > 0)
				$error("%0d expected results never arrived", expected_grants.size());
			$display("** fixed_partition_fit_allocator: FAILED **");
		end
		$finish;
	end

	// Bound the run
	initial begin
		#3000000;
		$display("** fixed_partition_fit_allocator: FAILED **");
		$finish;
	end

endmodule

### sim.f
hdl/fpfa_pkg.sv
hdl/fpfa_size_ram.sv
hdl/fpfa_ctrl.sv
hdl/fixed_partition_fit_allocator.sv
bench/tb_fixed_partition_fit_allocator.sv
